### src/swfg_pkg.sv
`timescale 1ns / 1ps

package swfg_pkg;

  // Request codes carried in the input item.
  typedef enum logic [1:0] {
    REQ_FIELD_WR = 2'd0,
    REQ_XW_WR    = 2'd1,
    REQ_YW_WR    = 2'd2,
    REQ_EVAL     = 2'd3
  } req_e;

  // Configuration register indexes and widths.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 1'b1;
  localparam logic [CFG_DATA_W-1:0] LIMIT_RESET = 9'd256;

  localparam int unsigned WEIGHT_SLOTS = 8;

  typedef struct packed {
    req_e               req_type;
    logic               plane;
    logic [7:0]         column;
    logic [7:0]         row;
    logic [2:0]         slot;
    logic signed [31:0] value;
    logic [3:0]         x_count;
    logic [3:0]         y_count;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] grad_x;
    logic signed [63:0] grad_y;
  } out_item_t;

  // Control from the sequencer to one plane unit.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic acc_clr;
    logic tap_vld;
    logic tap_use;
  } plane_ctl_t;

endpackage

### src/swfg_plane.sv
`timescale 1ns / 1ps

module swfg_plane import swfg_pkg::*; #(
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  plane_ctl_t               ctl_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [31:0]              wdata_i,
  input  logic [63:0]              prod_i,
  output logic [63:0]              acc_o,
  output logic                     busy_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_q;
  logic [31:0] f_q;
  logic [63:0] lo_d, lo_q;
  logic [31:0] hmul;
  logic [31:0] hi_d, hi_q;
  logic [63:0] term_q;
  logic [63:0] acc_q;
  logic        v3_q, v4_q;

  // Field plane storage with a registered read port.
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[addr_i] <= wdata_i;
    end
    if (ctl_i.rd_en) begin
      rdata_q <= mem[addr_i];
    end
  end

  // Low 64 bits of weight product times sign-extended field word. The
  // product splits into two 32-bit halves; a negative field word subtracts
  // the low half from the upper word.
  always_comb begin
    lo_d = prod_i[31:0] * f_q;
    hmul = prod_i[63:32] * f_q;
    hi_d = hmul - (f_q[31] ? prod_i[31:0] : 32'd0);
  end

  // Align the field word with the product stage, then multiply, combine
  // and accumulate.
  always_ff @(posedge clk_i) begin
    f_q <= rdata_q;
    if (ctl_i.tap_use) begin
      lo_q <= lo_d;
      hi_q <= hi_d;
    end else begin
      lo_q <= '0;
      hi_q <= '0;
    end
    term_q <= lo_q + {hi_q, 32'd0};
    if (ctl_i.acc_clr) begin
      acc_q <= '0;
    end else if (v4_q) begin
      acc_q <= acc_q + term_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v3_q <= ctl_i.tap_vld;
      v4_q <= v3_q;
    end
  end

  assign acc_o  = acc_q;
  assign busy_o = v3_q | v4_q;

  // A tap never reads while a field word is written.
  a_rd_wr_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl_i.rd_en && ctl_i.wr_en))
    else $error("plane read and write in the same cycle");

  // Accumulation is never cleared while taps are still in flight.
  a_clr_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.acc_clr |-> !(v3_q || v4_q))
    else $error("accumulator cleared while busy");

  // Every accessed address lies below the depth.
  a_addr_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.rd_en || ctl_i.wr_en) |-> ({1'b0, addr_i} < (AW + 1)'(DEPTH)))
    else $error("plane address beyond depth");

endmodule

### src/separable_window_field_gather.sv
`timescale 1ns / 1ps

// Separable window field gather.
// Input channel (in_valid_i / in_ready_o, in_item_i) takes field writes,
// x and y weight writes and evaluate requests. Writes complete in the cycle
// they are accepted and the block is ready again at once, so writes stream
// at one item per cycle. An evaluate request makes one result item on the
// output channel (out_valid_o / out_ready_i, out_item_o); writes make none.
// An evaluation walks its kc*hc taps (kc, hc saturated to MAX_TAPS) at one
// tap per cycle, set by the single read port of each plane memory, then
// drains a five-stage multiply-accumulate pipeline; when either count is
// zero it skips the walk and only drains. The input stays closed during an
// evaluation and opens in the cycle the result appears, so a new evaluation
// is not taken before the previous one has finished.
// The result sits in an output register; the next items are accepted while
// it waits. If the receiver stalls, a following evaluation finishes its
// taps and then holds until the old result is taken.
// The configuration port (cfg_we_i, cfg_index_i, cfg_wdata_i) sets the columns and rows
// in use; the user must write it only while the block is idle (the block does not enforce it).
module separable_window_field_gather import swfg_pkg::*; #(
  parameter int unsigned COLUMNS  = 256,
  parameter int unsigned ROWS     = 256,
  parameter int unsigned MAX_TAPS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_item_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned DEPTH = COLUMNS * ROWS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = ($clog2(COLUMNS + 1) > $clog2(ROWS + 1)) ?
                                  $clog2(COLUMNS + 1) : $clog2(ROWS + 1);
  localparam int unsigned LIM_W = (CW > CFG_DATA_W + 1) ? CW : CFG_DATA_W + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  state_e                state_q;
  logic [3:0]            k_q, h_q, kc_q, hc_q;
  logic [7:0]            col0_q, row0_q;
  logic                  out_valid_q;
  out_item_t             out_q;
  logic [CFG_DATA_W-1:0] cols_q, rows_q;

  logic signed [31:0] xw_q [WEIGHT_SLOTS];
  logic signed [31:0] yw_q [WEIGHT_SLOTS];

  logic               v1_q, use1_q, v2_q, use2_q;
  logic signed [31:0] px1_q, py1_q;
  logic signed [63:0] prod_d;
  logic [63:0]        prod2_q;

  logic                 accept;
  logic                 is_eval, is_fwr;
  logic [3:0]           kc_sat, hc_sat;
  logic [LIM_W-1:0]     col_tap, row_tap, wr_col, wr_row;
  logic                 tap_use, wr_ok, last_h, last_k, out_free;
  logic [AW-1:0]        addr;
  plane_ctl_t           ctl_x, ctl_y;
  logic [63:0]          acc_x, acc_y;
  logic                 busy_x, busy_y;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i & in_ready_o;
  assign is_eval    = (in_item_i.req_type == REQ_EVAL);
  assign is_fwr     = (in_item_i.req_type == REQ_FIELD_WR);
  assign kc_sat     = (in_item_i.x_count > 4'(MAX_TAPS)) ? 4'(MAX_TAPS) : in_item_i.x_count;
  assign hc_sat     = (in_item_i.y_count > 4'(MAX_TAPS)) ? 4'(MAX_TAPS) : in_item_i.y_count;
  assign out_free   = !out_valid_q || out_ready_i;

  // Tap position and its range checks against the limits in use and the array size; write range check and address.
  always_comb begin
    col_tap = LIM_W'(col0_q) + LIM_W'(k_q);
    row_tap = LIM_W'(row0_q) + LIM_W'(h_q);
    wr_col  = LIM_W'(in_item_i.column);
    wr_row  = LIM_W'(in_item_i.row);
    tap_use = (col_tap < LIM_W'(cols_q)) && (col_tap < LIM_W'(COLUMNS)) &&
              (row_tap < LIM_W'(rows_q)) && (row_tap < LIM_W'(ROWS));
    wr_ok   = (wr_col < LIM_W'(COLUMNS)) && (wr_row < LIM_W'(ROWS));
    if (state_q == ST_RUN) begin
      addr = AW'(col_tap * ROWS + row_tap);
    end else begin
      addr = AW'(wr_col * ROWS + wr_row);
    end
    last_h = (h_q == hc_q - 4'd1);
    last_k = (k_q == kc_q - 4'd1);
  end

  // Per-plane control.
  always_comb begin
    ctl_x.wr_en   = accept && is_fwr && wr_ok && !in_item_i.plane;
    ctl_y.wr_en   = accept && is_fwr && wr_ok && in_item_i.plane;
    ctl_x.rd_en   = (state_q == ST_RUN) && tap_use;
    ctl_y.rd_en   = ctl_x.rd_en;
    ctl_x.acc_clr = accept && is_eval;
    ctl_y.acc_clr = ctl_x.acc_clr;
    ctl_x.tap_vld = v2_q;
    ctl_y.tap_vld = v2_q;
    ctl_x.tap_use = use2_q;
    ctl_y.tap_use = use2_q;
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= LIMIT_RESET;
      rows_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_COLS_IN_USE: cols_q <= cfg_wdata_i;
        REG_ROWS_IN_USE: rows_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Weight slots and the evaluate request's window.
  always_ff @(posedge clk_i) begin
    if (accept && (in_item_i.req_type == REQ_XW_WR)) begin
      xw_q[in_item_i.slot] <= in_item_i.value;
    end
    if (accept && (in_item_i.req_type == REQ_YW_WR)) begin
      yw_q[in_item_i.slot] <= in_item_i.value;
    end
    if (accept && is_eval) begin
      col0_q <= in_item_i.column;
      row0_q <= in_item_i.row;
      kc_q   <= kc_sat;
      hc_q   <= hc_sat;
    end
  end

  // Sequencer: tap walk, drain and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      h_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // In the done state a taken result is replaced by the new one below.
      if (out_valid_q && out_ready_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept && is_eval) begin
            k_q <= '0;
            h_q <= '0;
            if (kc_sat == 4'd0 || hc_sat == 4'd0) begin
              state_q <= ST_DRAIN;
            end else begin
              state_q <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          if (last_h) begin
            h_q <= '0;
            k_q <= k_q + 4'd1;
            if (last_k) begin
              state_q <= ST_DRAIN;
            end
          end else begin
            h_q <= h_q + 4'd1;
          end
        end
        ST_DRAIN: begin
          if (!v1_q && !v2_q && !busy_x && !busy_y) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_q.grad_x <= acc_x;
            out_q.grad_y <= acc_y;
            out_valid_q  <= 1'b1;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Weight fetch and weight product, aligned with the memory reads.
  assign prod_d = px1_q * py1_q;

  always_ff @(posedge clk_i) begin
    px1_q   <= xw_q[k_q[2:0]];
    py1_q   <= yw_q[h_q[2:0]];
    use1_q  <= tap_use;
    use2_q  <= use1_q;
    prod2_q <= prod_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= (state_q == ST_RUN);
      v2_q <= v1_q;
    end
  end

  swfg_plane #(
    .DEPTH(DEPTH)
  ) u_plane_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl_x),
    .addr_i (addr),
    .wdata_i(in_item_i.value),
    .prod_i (prod2_q),
    .acc_o  (acc_x),
    .busy_o (busy_x)
  );

  swfg_plane #(
    .DEPTH(DEPTH)
  ) u_plane_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl_y),
    .addr_i (addr),
    .wdata_i(in_item_i.value),
    .prod_i (prod2_q),
    .acc_o  (acc_y),
    .busy_o (busy_y)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // The input opens only once no tap is left in the weight stages.
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !(v1_q || v2_q))
    else $error("input ready while taps in flight");

  // The tap counters stay inside the window while walking.
  a_tap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> ((k_q < kc_q) && (h_q < hc_q)))
    else $error("tap counter outside window");

  // A waiting result is never overwritten by the next evaluation.
  a_done_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DONE) && out_valid_o && !out_ready_i) |=> (state_q == ST_DONE))
    else $error("result overwritten while stalled");

  // A new result only appears at the end of an evaluation.
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_DONE))
    else $error("result without evaluation");

endmodule

### tb/tb_separable_window_field_gather.sv
`timescale 1ns / 1ps

module tb_separable_window_field_gather;
  import swfg_pkg::*;

  localparam int unsigned COLUMNS      = 256;
  localparam int unsigned ROWS         = 256;
  localparam int unsigned MAX_TAPS     = 8;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned PHASE_ITEMS  = 228;
  localparam int unsigned NUM_PHASES   = 8;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready_o;
  in_item_t              in_item = '0;
  logic                  out_valid_o;
  logic                  out_ready = 1'b0;
  out_item_t             out_item_o;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_COLS_IN_USE;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Mirror of the block state, updated as items are accepted.
  bit [31:0]   field_mirror [2][COLUMNS][ROWS];
  bit [31:0]   xw_mirror [WEIGHT_SLOTS];
  bit [31:0]   yw_mirror [WEIGHT_SLOTS];
  int unsigned cols_lim = LIMIT_RESET;
  int unsigned rows_lim = LIMIT_RESET;

  // Field cells that some queued write already covers.
  bit          seeded [2][COLUMNS][ROWS];

  in_item_t    req_backlog [$];
  out_item_t   grad_expect_q [$];
  out_item_t   grad_want;

  int          idle_pct = 0;
  int          stall_pct = 0;
  int          gap_left = 0;
  int          stall_left = 0;
  int unsigned quiet_cycles = 0;
  int          mismatches = 0;
  int          n_field = 0;
  int          n_weight = 0;
  int          n_eval = 0;
  int          n_checked = 0;

  separable_window_field_gather u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_wdata_i(cfg_wdata)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Weighted window sum over both planes, wrapping at 64 bits.
  function automatic out_item_t gather_window(in_item_t it);
    out_item_t   res;
    longint      acc_x;
    longint      acc_y;
    longint      wx;
    longint      wxy;
    int unsigned clim;
    int unsigned rlim;
    int unsigned ncol;
    int unsigned nrow;
    int unsigned col;
    int unsigned row;
    clim = (cols_lim < COLUMNS) ? cols_lim : COLUMNS;
    rlim = (rows_lim < ROWS) ? rows_lim : ROWS;
    ncol = (it.x_count > MAX_TAPS) ? MAX_TAPS : it.x_count;
    nrow = (it.y_count > MAX_TAPS) ? MAX_TAPS : it.y_count;
    acc_x = 0;
    acc_y = 0;
    for (int k = 0; k < ncol; k++) begin
      col = it.column + k;
      // Columns out of use are skipped; rows out of use add nothing.
      if (col < clim) begin
        wx = longint'($signed(xw_mirror[k]));
        for (int h = 0; h < nrow; h++) begin
          row = it.row + h;
          if (row < rlim) begin
            wxy = wx * longint'($signed(yw_mirror[h]));
            acc_x += wxy * longint'($signed(field_mirror[0][col][row]));
            acc_y += wxy * longint'($signed(field_mirror[1][col][row]));
          end
        end
      end
    end
    res.grad_x = acc_x;
    res.grad_y = acc_y;
    return res;
  endfunction

  // Apply one accepted item to the mirror or queue its expected sums.
  task automatic absorb_item(in_item_t it);
    case (it.req_type)
      REQ_FIELD_WR: begin
        field_mirror[it.plane][it.column][it.row] = it.value;
        n_field++;
      end
      REQ_XW_WR: begin
        xw_mirror[it.slot] = it.value;
        n_weight++;
      end
      REQ_YW_WR: begin
        yw_mirror[it.slot] = it.value;
        n_weight++;
      end
      default: begin
        grad_expect_q.push_back(gather_window(it));
        n_eval++;
      end
    endcase
  endtask

  // An item with every field random; callers set the fields that matter.
  function automatic in_item_t junk_item();
    logic [63:0] r;
    in_item_t    it;
    r = {$urandom, $urandom};
    it = r[$bits(in_item_t)-1:0];
    return it;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0001;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [3:0] rand_taps();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 6) return 4'd0;
    if (pick < 88) return 4'($urandom_range(1, MAX_TAPS));
    return 4'($urandom_range(MAX_TAPS + 1, 15));
  endfunction

  function automatic logic [7:0] rand_origin();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) return 8'($urandom_range(0, 19));
    if (pick < 80) return 8'($urandom_range(236, 255));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void push_field(logic plane, logic [7:0] col, logic [7:0] row,
                                     logic [31:0] val);
    in_item_t it;
    it = junk_item();
    it.req_type = REQ_FIELD_WR;
    it.plane = plane;
    it.column = col;
    it.row = row;
    it.value = val;
    seeded[plane][col][row] = 1'b1;
    req_backlog.push_back(it);
  endfunction

  function automatic void push_weight(req_e kind, logic [2:0] slot, logic [31:0] val);
    in_item_t it;
    it = junk_item();
    it.req_type = kind;
    it.slot = slot;
    it.value = val;
    req_backlog.push_back(it);
  endfunction

  // Queues writes for every unwritten cell under the window, then the evaluation.
  function automatic int push_eval(logic [7:0] col, logic [7:0] row,
                                   logic [3:0] xc, logic [3:0] yc);
    in_item_t    it;
    int          made;
    int unsigned ncol;
    int unsigned nrow;
    made = 1;
    ncol = (xc > MAX_TAPS) ? MAX_TAPS : xc;
    nrow = (yc > MAX_TAPS) ? MAX_TAPS : yc;
    for (int k = 0; k < ncol; k++) begin
      for (int h = 0; h < nrow; h++) begin
        for (int p = 0; p < 2; p++) begin
          if (col + k < COLUMNS && row + h < ROWS && !seeded[p][col + k][row + h]) begin
            push_field(1'(p), 8'(col + k), 8'(row + h), rand_word());
            made++;
          end
        end
      end
    end
    it = junk_item();
    it.req_type = REQ_EVAL;
    it.column = col;
    it.row = row;
    it.x_count = xc;
    it.y_count = yc;
    req_backlog.push_back(it);
    return made;
  endfunction

  // Random traffic: mostly evaluations with fresh weights, plus stray writes.
  task automatic fill_phase(int quota);
    int          made;
    int unsigned pick;
    made = 0;
    while (made < quota) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        repeat ($urandom_range(0, 2)) begin
          push_weight($urandom_range(0, 1) ? REQ_XW_WR : REQ_YW_WR,
                      3'($urandom_range(0, 7)), rand_word());
          made++;
        end
        made += push_eval(rand_origin(), rand_origin(), rand_taps(), rand_taps());
      end else if (pick < 85) begin
        push_field(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), rand_word());
        made++;
      end else begin
        push_weight($urandom_range(0, 1) ? REQ_XW_WR : REQ_YW_WR,
                    3'($urandom_range(0, 7)), rand_word());
        made++;
      end
    end
  endtask

  // Wait until nothing is queued, offered or owed by the block.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (req_backlog.size() != 0 || in_valid || grad_expect_q.size() != 0);
  endtask

  // Both limit registers, one write per cycle.
  task automatic apply_limits(int unsigned cols, int unsigned rows);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_index <= REG_COLS_IN_USE;
    cfg_wdata <= CFG_DATA_W'(cols);
    @(posedge clk_i);
    cfg_index <= REG_ROWS_IN_USE;
    cfg_wdata <= CFG_DATA_W'(rows);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    cols_lim = cols;
    rows_lim = rows;
  endtask

  // Input driver: offers backlog items with random idle bursts.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_item <= '0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready_o) begin
        absorb_item(in_item);
      end
      if (!in_valid || in_ready_o) begin
        if (gap_left == 0 && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
          gap_left = $urandom_range(1, 3);
        end
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (req_backlog.size() != 0) begin
          in_item <= req_backlog.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each result against the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (grad_expect_q.size() == 0) begin
          $display("%0t: unexpected result grad_x %0d grad_y %0d", $time,
                   out_item_o.grad_x, out_item_o.grad_y);
          mismatches++;
        end else begin
          grad_want = grad_expect_q.pop_front();
          if (out_item_o.grad_x !== grad_want.grad_x) begin
            $display("%0t: grad_x expected %0d, got %0d", $time,
                     grad_want.grad_x, out_item_o.grad_x);
            mismatches++;
          end
          if (out_item_o.grad_y !== grad_want.grad_y) begin
            $display("%0t: grad_y expected %0d, got %0d", $time,
                     grad_want.grad_y, out_item_o.grad_y);
            mismatches++;
          end
          n_checked++;
        end
      end
      if (stall_left == 0 && stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(1, 3);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any accepted item on either channel.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: timeout, no item moved for %0d cycles", $time, quiet_cycles);
        $display("separable_window_field_gather regression: fail");
        $finish;
      end
    end
  end

  // Sequencer: directed items, then random phases over several limit settings.
  initial begin
    int unsigned ph_cols [NUM_PHASES];
    int unsigned ph_rows [NUM_PHASES];
    int          ph_idle [NUM_PHASES];
    int          ph_stall [NUM_PHASES];
    ph_cols  = '{256, 1, 256, 1, 12, 245, 0, 256};
    ph_rows  = '{256, 1, 1, 256, 9, 250, 0, 256};
    ph_idle  = '{30, 20, 0, 40, 25, 30, 20, 0};
    ph_stall = '{30, 0, 40, 20, 25, 30, 20, 0};
    ph_cols[6] = $urandom_range(1, 256);
    ph_rows[6] = $urandom_range(1, 256);
    idle_pct = 25;
    stall_pct = 25;

    // Extreme weights in the low slots: most negative in slot 0, most positive x and minus one y in slot 1.
    push_weight(REQ_XW_WR, 3'd0, 32'h8000_0000);
    push_weight(REQ_XW_WR, 3'd1, 32'h7fff_ffff);
    push_weight(REQ_YW_WR, 3'd0, 32'h8000_0000);
    push_weight(REQ_YW_WR, 3'd1, 32'hffff_ffff);
    for (int s = 2; s < WEIGHT_SLOTS; s++) begin
      push_weight(REQ_XW_WR, 3'(s), $urandom);
      push_weight(REQ_YW_WR, 3'(s), $urandom);
    end
    // Corner cells at both extremes of the field value.
    push_field(1'b0, 8'd0, 8'd0, 32'h8000_0000);
    push_field(1'b1, 8'd0, 8'd0, 32'h8000_0000);
    push_field(1'b0, 8'd255, 8'd255, 32'h7fff_ffff);
    push_field(1'b1, 8'd255, 8'd255, 32'h7fff_ffff);
    // Single tap with the largest product, oversized counts at the far corner,
    // and zero column taps and zero row taps.
    void'(push_eval(8'd0, 8'd0, 4'd1, 4'd1));
    void'(push_eval(8'd255, 8'd255, 4'd15, 4'd15));
    void'(push_eval(8'd0, 8'd0, 4'd0, 4'd5));
    void'(push_eval(8'd255, 8'd255, 4'd3, 4'd0));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clk_i);
      apply_limits(ph_cols[p], ph_rows[p]);
      idle_pct = ph_idle[p];
      stall_pct = ph_stall[p];
      fill_phase(PHASE_ITEMS);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Covered %0d field writes, %0d weight writes and %0d window evaluations",
             n_field, n_weight, n_eval);
    $display("over %0d column/row limit settings; %0d results compared, %0d mismatches.",
             NUM_PHASES + 1, n_checked, mismatches);
    if (mismatches == 0) begin
      $display("separable_window_field_gather regression: pass");
    end else begin
      $display("separable_window_field_gather regression: fail");
    end
    $finish;
  end

endmodule
